[design/weighted_priority_job_queue_core_macros.svh]
// assertion macros for the weighted priority job queue
// used by the port checker, no other dependencies
`ifndef WEIGHTED_PRIORITY_JOB_QUEUE_CORE_MACROS_SVH
`define WEIGHTED_PRIORITY_JOB_QUEUE_CORE_MACROS_SVH

// property checked at every clock edge outside reset
`define WPJQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wpjq assertion failed");

// antecedent followed by a consequent in the next cycle
`define WPJQ_ASSERT_NEXT(label, clk, rst_n, ante, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (conseq)) \
        else $error("wpjq sequence assertion failed");

`endif

[design/wpjq_pkg.sv]
// types, codes and helper functions for the weighted priority job queue
// no dependencies
package wpjq_pkg;

    localparam int PRIO_W = 5;
    localparam int CODE_W = 16;
    localparam int OCC_W  = 5;

    localparam logic [5:0] ROLE_WEIGHT = 6'd3;
    localparam logic [5:0] DEPT_WEIGHT = 6'd2;
    localparam logic [3:0] URG_LOW     = 4'd1;
    localparam logic [3:0] URG_MID     = 4'd5;
    localparam logic [3:0] URG_HIGH    = 4'd10;
    localparam logic [2:0] DEPT_MIN    = 3'd1;
    localparam logic [2:0] DEPT_MAX    = 3'd4;
    localparam logic [2:0] ROLE_MIN    = 3'd1;
    localparam logic [2:0] ROLE_MAX    = 3'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] department;
        logic [2:0] role;
        logic [3:0] urgency;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [CODE_W-1:0]   job_code;
        logic [PRIO_W-1:0]   job_priority;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [CODE_W-1:0] code;
    } entry_t;

    // read address source of the entry memory
    typedef enum logic [2:0] {
        RD_ZERO    = 3'd0,
        RD_ONE     = 3'd1,
        RD_TAIL    = 3'd2,
        RD_IDX_DEC = 3'd3,
        RD_IDX_INC = 3'd4
    } rd_sel_t;

    // write address and data source of the entry memory
    typedef enum logic [1:0] {
        WR_NEW_ZERO   = 2'd0,
        WR_NEW_ABOVE  = 2'd1,
        WR_SHIFT_UP   = 2'd2,
        WR_SHIFT_DOWN = 2'd3
    } wr_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD = 3'd0,
        IDX_TAIL = 3'd1,
        IDX_ONE  = 3'd2,
        IDX_DEC  = 3'd3,
        IDX_INC  = 3'd4
    } idx_op_t;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        idx_op_t idx_op;
        logic    hold_head;
        logic    finish;
        status_t fin_status;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic fields_ok;
        logic full;
        logic empty;
        logic count_one;
        logic rd_greater;
        logic idx_zero;
        logic idx_last;
    } dp_status_t;

    function automatic logic fields_valid(
        input logic [2:0] dept,
        input logic [2:0] role,
        input logic [3:0] urg
    );
        logic ok;
        ok = (dept inside {[DEPT_MIN:DEPT_MAX]}) && (role inside {[ROLE_MIN:ROLE_MAX]})
            && (urg inside {URG_LOW, URG_MID, URG_HIGH});
        return ok;
    endfunction

    function automatic logic [PRIO_W-1:0] calc_priority(
        input logic [2:0] dept,
        input logic [2:0] role,
        input logic [3:0] urg
    );
        logic [5:0] sum;
        sum = 6'(role) * ROLE_WEIGHT + 6'(dept) * DEPT_WEIGHT + 6'(urg);
        return sum[PRIO_W-1:0];
    endfunction

endpackage

[design/weighted_priority_job_queue_core.sv]
// weighted priority job queue: sorted insert by priority, pop from the head
// an insert scans from the tail toward the head and a pop shifts the remaining entries down;
// each step moves one entry through the one-read one-write entry memory
// busy is high while an item is at work; the next start may come in the cycle done shows
// each result is a one-cycle transfer on done; reset clears job count and code counter
// the entry memory is not cleared, slots above the job count are never read
module weighted_priority_job_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  wpjq_pkg::item_t    item,
    output logic               busy,
    output logic               done,
    output wpjq_pkg::result_t  result
);
    import wpjq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    wpjq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .cmd    (cmd),
        .busy   (busy)
    );

    wpjq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (dp_status),
        .result (result),
        .done   (done)
    );

endmodule

[design/wpjq_datapath.sv]
// datapath of the weighted priority job queue: entry memory, counters, result register
// depends on wpjq_pkg
module wpjq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wpjq_pkg::item_t        item,
    input  wpjq_pkg::ctrl_cmd_t    cmd,
    output wpjq_pkg::dp_status_t   status,
    output wpjq_pkg::result_t      result,
    output logic                   done
);
    import wpjq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [IDX_W-1:0] IDX_ONE_V = IDX_W'(1);

    entry_t            entry_mem [QUEUE_DEPTH];
    entry_t            rd_data_reg;
    op_t               op_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic              fields_ok_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    entry_t            head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CODE_W-1:0] next_code_reg;
    logic [CODE_W-1:0] next_code_next;
    result_t           result_reg;
    result_t           result_next;
    logic              done_reg;

    logic [IDX_W-1:0]   tail_idx;
    logic [IDX_W-1:0]   idx_plus;
    logic [IDX_W-1:0]   idx_minus;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    entry_t             new_entry;
    logic [CNT_W+4:0]   occ_wide;

    assign tail_idx  = IDX_W'(count_reg - CNT_ONE);
    assign idx_plus  = idx_reg + IDX_ONE_V;
    assign idx_minus = idx_reg - IDX_ONE_V;
    assign new_entry = '{prio: prio_reg, code: next_code_reg};

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO:    rd_addr = '0;
            RD_ONE:     rd_addr = IDX_ONE_V;
            RD_TAIL:    rd_addr = tail_idx;
            RD_IDX_DEC: rd_addr = idx_minus;
            RD_IDX_INC: rd_addr = idx_plus;
            default:    rd_addr = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_NEW_ZERO:
            begin
                wr_addr = '0;
                wr_data = new_entry;
            end
            WR_NEW_ABOVE:
            begin
                wr_addr = idx_plus;
                wr_data = new_entry;
            end
            WR_SHIFT_UP:
            begin
                wr_addr = idx_plus;
                wr_data = rd_data_reg;
            end
            WR_SHIFT_DOWN:
            begin
                wr_addr = idx_minus;
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = '0;
                wr_data = new_entry;
            end
        endcase
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_TAIL: idx_next = tail_idx;
            IDX_ONE:  idx_next = IDX_ONE_V;
            IDX_DEC:  idx_next = idx_minus;
            IDX_INC:  idx_next = idx_plus;
            default:  idx_next = idx_reg;
        endcase
    end

    // result of a finished item, counters advance only on a successful transfer
    always_comb
    begin
        count_next     = count_reg;
        next_code_next = next_code_reg;
        result_next    = result_reg;
        if (cmd.finish)
        begin
            result_next.status       = cmd.fin_status;
            result_next.job_code     = '0;
            result_next.job_priority = '0;
            case (cmd.fin_status)
                ST_OK:
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        count_next               = count_reg + CNT_ONE;
                        next_code_next           = next_code_reg + CODE_W'(1);
                        result_next.job_code     = next_code_reg;
                        result_next.job_priority = prio_reg;
                    end
                    else
                    begin
                        count_next               = count_reg - CNT_ONE;
                        result_next.job_code     = head_reg.code;
                        result_next.job_priority = head_reg.prio;
                    end
                end
                ST_FULL:
                begin
                    result_next.job_priority = prio_reg;
                end
                default:
                begin
                    result_next.job_priority = '0;
                end
            endcase
            occ_wide = {5'b0, count_next};
            result_next.occupancy = occ_wide[OCC_W-1:0];
        end
        else
        begin
            occ_wide = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= item.op;
            prio_reg      <= calc_priority(item.department, item.role, item.urgency);
            fields_ok_reg <= fields_valid(item.department, item.role, item.urgency);
        end
        if (cmd.hold_head)
        begin
            head_reg <= rd_data_reg;
        end
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            next_code_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            next_code_reg <= next_code_next;
            done_reg      <= cmd.finish;
        end
    end

    assign status.op         = op_reg;
    assign status.fields_ok  = fields_ok_reg;
    assign status.full       = (count_reg == DEPTH_CNT);
    assign status.empty      = (count_reg == '0);
    assign status.count_one  = (count_reg == CNT_ONE);
    assign status.rd_greater = (rd_data_reg.prio > prio_reg);
    assign status.idx_zero   = (idx_reg == '0);
    assign status.idx_last   = ((CNT_W'(idx_reg) + CNT_ONE) == count_reg);

    assign result = result_reg;
    assign done   = done_reg;

endmodule

[design/wpjq_ctrl.sv]
// controller of the weighted priority job queue: sequences insert scan and pop shift
// depends on wpjq_pkg
module wpjq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  wpjq_pkg::dp_status_t  status,
    output wpjq_pkg::ctrl_cmd_t   cmd,
    output logic                  busy
);
    import wpjq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_INS_SCAN = 7'b0000100,
        S_INS_LAST = 7'b0001000,
        S_POP_HEAD = 7'b0010000,
        S_POP_SHIFT = 7'b0100000,
        S_POP_FIN  = 7'b1000000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.op == OP_INSERT)
                begin
                    if (!status.fields_ok)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_INVALID;
                        state_next     = S_IDLE;
                    end
                    else if (status.full)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_FULL;
                        state_next     = S_IDLE;
                    end
                    else if (status.empty)
                    begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_sel     = WR_NEW_ZERO;
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_OK;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_TAIL;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_TAIL;
                        state_next = S_INS_SCAN;
                    end
                end
                else if (status.empty)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_EMPTY;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ZERO;
                    state_next = S_POP_HEAD;
                end
            end
            S_INS_SCAN:
            begin
                // walk from the tail toward the head, moving lower or equal entries up
                cmd.wr_en = 1'b1;
                if (status.rd_greater)
                begin
                    cmd.wr_sel     = WR_NEW_ABOVE;
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.wr_sel = WR_SHIFT_UP;
                    if (status.idx_zero)
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_DEC;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_IDX_DEC;
                    end
                end
            end
            S_INS_LAST:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = WR_NEW_ZERO;
                cmd.finish     = 1'b1;
                cmd.fin_status = ST_OK;
                state_next     = S_IDLE;
            end
            S_POP_HEAD:
            begin
                cmd.hold_head = 1'b1;
                if (status.count_one)
                begin
                    state_next = S_POP_FIN;
                end
                else
                begin
                    cmd.idx_op = IDX_ONE;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ONE;
                    state_next = S_POP_SHIFT;
                end
            end
            S_POP_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT_DOWN;
                if (status.idx_last)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_INC;
                end
            end
            S_POP_FIN:
            begin
                cmd.finish     = 1'b1;
                cmd.fin_status = ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[design/wpjq_checker.sv]
// port-level checker for the weighted priority job queue, bound to the top level
// depends on wpjq_pkg and weighted_priority_job_queue_core_macros.svh
`include "weighted_priority_job_queue_core_macros.svh"

module wpjq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input wpjq_pkg::result_t  result
);
    import wpjq_pkg::*;

    // an accepted item makes the block busy, nothing else does
    `WPJQ_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `WPJQ_ASSERT_NEXT(a_idle_holds, clk, rst_n, !start && !busy, !busy)
    // one result per item, never two in a row
    `WPJQ_ASSERT_NEXT(a_done_gap, clk, rst_n, done, !done)
    `WPJQ_ASSERT(a_done_after_work, clk, rst_n, done |-> $past(busy))
    `WPJQ_ASSERT(a_empty_occ, clk, rst_n, done && result.status == ST_EMPTY |-> result.occupancy == '0)

endmodule

bind weighted_priority_job_queue_core wpjq_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
